[design/mmi_pkg.sv]
// ----------------------------------------------------------------------------
// mmi_pkg: shared types, constants and helpers for the modular 3x3 inverse
// Holds the residue and product widths, the cofactor operand map, a small
// conditional-subtract reducer and the elaboration-time inverse table builder.
// ----------------------------------------------------------------------------
package mmi_pkg;

    // Every residue and key entry is five bits wide; a product of two is ten.
    localparam int RES_W       = 5;
    localparam int PROD_W      = 2 * RES_W;
    localparam int MODULUS_DEF = 26;
    localparam int N_ENT       = 9;
    localparam int INV_DEPTH   = 1 << RES_W;

    typedef logic [RES_W-1:0]  t_res;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [INV_DEPTH-1:0][RES_W-1:0] t_inv_tab;

    // Determinant, its inverse and the invertible flag travel together.
    typedef struct packed {
        t_res det;
        t_res inv;
        logic invertible;
    } t_det_info;

    // Operand indices (row * 3 + column) for each signed cofactor a*b - c*d.
    // Negative cofactors are formed by swapping the two products.
    localparam int COF_IDX [N_ENT][4] = '{
        '{4, 8, 5, 7},
        '{5, 6, 3, 8},
        '{3, 7, 4, 6},
        '{2, 7, 1, 8},
        '{0, 8, 2, 6},
        '{1, 6, 0, 7},
        '{1, 5, 2, 4},
        '{2, 3, 0, 5},
        '{0, 4, 1, 3}
    };

    // Clamps a modulus below two up to two.
    function automatic t_res mod_const(input int m);
        return t_res'((m < 2) ? 2 : m);
    endfunction

    // Reduces x modulo m by restoring subtraction; valid for x < m * 2**RES_W.
    function automatic t_res mod_reduce(input t_prod x, input t_res m);
        t_prod v;
        v = x;
        for (int s = RES_W - 1; s >= 0; s--) begin
            if (v >= (t_prod'(m) << s)) begin
                v = v - (t_prod'(m) << s);
            end
        end
        return t_res'(v);
    endfunction

    // Builds the table of multiplicative inverses modulo m; zero means none.
    function automatic t_inv_tab build_inv_table(input int m);
        t_inv_tab tab;
        int       acc;
        tab = '0;
        for (int a = 0; a < INV_DEPTH; a++) begin
            if (a < m) begin
                acc = 0;
                for (int x = 1; x < m; x++) begin
                    acc = acc + a;
                    if (acc >= m) begin
                        acc = acc - m;
                    end
                    if ((acc == 1) && (tab[a] == '0)) begin
                        tab[a] = t_res'(x);
                    end
                end
            end
        end
        return tab;
    endfunction

endpackage

[design/mmi_cof_lane.sv]
// ----------------------------------------------------------------------------
// mmi_cof_lane: one cofactor lane
// Forms (a*b - c*d) mod MODULUS over two register stages: the raw products
// first, then the reduction and the nonnegative difference.
// ----------------------------------------------------------------------------
module mmi_cof_lane
    import mmi_pkg::*;
#(
    parameter int MODULUS = MODULUS_DEF
) (
    input  logic i_clk,
    input  t_res i_a,
    input  t_res i_b,
    input  t_res i_c,
    input  t_res i_d,
    output t_res o_cof
);

    localparam t_res M = mod_const(MODULUS);

    t_prod r_p, r_q;
    t_res  r_cof;
    t_res  w_pr, w_qr;
    t_res  n_cof;

    // First stage: both raw products.
    always_ff @(posedge i_clk) begin
        r_p <= t_prod'(i_a) * t_prod'(i_b);
        r_q <= t_prod'(i_c) * t_prod'(i_d);
    end

    // Second stage: reduce each product and take the difference modulo M.
    always_comb begin
        w_pr = mod_reduce(r_p, M);
        w_qr = mod_reduce(r_q, M);
        if (w_pr >= w_qr) begin
            n_cof = w_pr - w_qr;
        end else begin
            n_cof = w_pr + M - w_qr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cof <= n_cof;
    end

    assign o_cof = r_cof;

endmodule

[design/mmi_det_merge.sv]
// ----------------------------------------------------------------------------
// mmi_det_merge: determinant and inverse merge stage
// Combines the first-row cofactors with the first-row key entries into the
// determinant, then looks up its inverse modulo MODULUS. Three register stages.
// ----------------------------------------------------------------------------
module mmi_det_merge
    import mmi_pkg::*;
#(
    parameter int MODULUS = MODULUS_DEF
) (
    input  logic      i_clk,
    input  t_res      i_k [3],
    input  t_res      i_cof [3],
    output t_det_info o_info
);

    localparam t_res     M       = mod_const(MODULUS);
    localparam t_inv_tab INV_TAB = build_inv_table(int'(M));

    t_prod     r_term [3];
    t_prod     r_sum;
    t_det_info r_info;
    t_prod     n_sum;
    t_res      n_det;
    t_res      n_inv;

    // Expansion terms along row 0.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_term[j] <= t_prod'(i_k[j]) * t_prod'(i_cof[j]);
        end
    end

    // Sum of the three reduced terms stays below 3*M, so one more reduction.
    always_comb begin
        n_sum = t_prod'(mod_reduce(r_term[0], M)) + t_prod'(mod_reduce(r_term[1], M))
              + t_prod'(mod_reduce(r_term[2], M));
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    // Final reduction and inverse lookup; a zero entry marks no inverse.
    assign n_det = mod_reduce(r_sum, M);
    assign n_inv = INV_TAB[n_det];

    always_ff @(posedge i_clk) begin
        r_info.det        <= n_det;
        r_info.inv        <= n_inv;
        r_info.invertible <= (n_inv != '0);
    end

    assign o_info = r_info;

endmodule

[design/mmi_scale_lane.sv]
// ----------------------------------------------------------------------------
// mmi_scale_lane: one output lane
// Multiplies an adjugate entry by the determinant inverse and reduces it,
// forcing zero when the key matrix is singular. Two register stages.
// ----------------------------------------------------------------------------
module mmi_scale_lane
    import mmi_pkg::*;
#(
    parameter int MODULUS = MODULUS_DEF
) (
    input  logic i_clk,
    input  t_res i_adj,
    input  t_res i_inv,
    input  logic i_invertible,
    output t_res o_res
);

    localparam t_res M = mod_const(MODULUS);

    t_prod r_prod;
    logic  r_ok;
    t_res  r_res;

    // Raw product, with the invertible flag kept alongside.
    always_ff @(posedge i_clk) begin
        r_prod <= t_prod'(i_adj) * t_prod'(i_inv);
        r_ok   <= i_invertible;
    end

    // Reduction into the output register.
    always_ff @(posedge i_clk) begin
        r_res <= r_ok ? mod_reduce(r_prod, M) : '0;
    end

    assign o_res = r_res;

endmodule

[design/modular_matrix_inverse_3x3.sv]
// ----------------------------------------------------------------------------
// modular_matrix_inverse_3x3: inverse of a 3x3 key matrix modulo MODULUS
// o_done is high in the same cycle as the results that it marks.
// Throughput: one matrix per cycle; nine cofactor lanes and nine output lanes
// run in parallel, and busy stays low in operation.
// Reset: synchronous, active low; it flushes the valid pipeline and holds busy
// high until the first cycle after reset. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module modular_matrix_inverse_3x3
    import mmi_pkg::*;
#(
    parameter int MODULUS = MODULUS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  logic [4:0] i_k00,
    input  logic [4:0] i_k01,
    input  logic [4:0] i_k02,
    input  logic [4:0] i_k10,
    input  logic [4:0] i_k11,
    input  logic [4:0] i_k12,
    input  logic [4:0] i_k20,
    input  logic [4:0] i_k21,
    input  logic [4:0] i_k22,
    output logic       o_done,
    output logic [4:0] o_r00,
    output logic [4:0] o_r01,
    output logic [4:0] o_r02,
    output logic [4:0] o_r10,
    output logic [4:0] o_r11,
    output logic [4:0] o_r12,
    output logic [4:0] o_r20,
    output logic [4:0] o_r21,
    output logic [4:0] o_r22,
    output logic [4:0] o_det_residue,
    output logic       o_invertible
);

    localparam t_res M     = mod_const(MODULUS);
    localparam int   LAT   = 8;

    logic            r_busy;
    logic [LAT-1:0]  r_vld;
    logic            w_accept;
    t_res            w_k_in [N_ENT];
    t_res            r_k    [N_ENT];
    t_res            r_k0_d1 [3];
    t_res            r_k0_d2 [3];
    t_res            w_cof  [N_ENT];
    t_res            r_cof_d1 [N_ENT];
    t_res            r_cof_d2 [N_ENT];
    t_res            r_cof_d3 [N_ENT];
    t_det_info       w_info;
    t_det_info       r_info_d1;
    t_det_info       r_info_d2;
    t_res            w_res  [N_ENT];

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    // Control: busy during reset, and the valid strobe pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[LAT-2:0], w_accept};
        end
    end

    assign o_done = r_vld[LAT-1];

    // Input entries, in row-major order.
    assign w_k_in = '{i_k00, i_k01, i_k02, i_k10, i_k11, i_k12, i_k20, i_k21, i_k22};

    // Capture the key matrix, reduced into 0..M-1.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_ENT; i++) begin
            r_k[i] <= mod_reduce(t_prod'(w_k_in[i]), M);
        end
    end

    // Cofactor lanes.
    for (genvar g = 0; g < N_ENT; g++) begin : g_cof
        mmi_cof_lane #(
            .MODULUS (MODULUS)
        ) u_cof (
            .i_clk (i_clk),
            .i_a   (r_k[COF_IDX[g][0]]),
            .i_b   (r_k[COF_IDX[g][1]]),
            .i_c   (r_k[COF_IDX[g][2]]),
            .i_d   (r_k[COF_IDX[g][3]]),
            .o_cof (w_cof[g])
        );
    end

    // Row 0 of the key follows the cofactor lanes so the merge sees both together.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_k0_d1[j] <= r_k[j];
            r_k0_d2[j] <= r_k0_d1[j];
        end
    end

    // Determinant and inverse.
    mmi_det_merge #(
        .MODULUS (MODULUS)
    ) u_det (
        .i_clk  (i_clk),
        .i_k    (r_k0_d2),
        .i_cof  (w_cof[0:2]),
        .o_info (w_info)
    );

    // Cofactors wait for the inverse; determinant info follows the output lanes.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_ENT; i++) begin
            r_cof_d1[i] <= w_cof[i];
            r_cof_d2[i] <= r_cof_d1[i];
            r_cof_d3[i] <= r_cof_d2[i];
        end
        r_info_d1 <= w_info;
        r_info_d2 <= r_info_d1;
    end

    // Output lanes: entry (r, c) of the inverse uses cofactor (c, r).
    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            mmi_scale_lane #(
                .MODULUS (MODULUS)
            ) u_scale (
                .i_clk        (i_clk),
                .i_adj        (r_cof_d3[c * 3 + r]),
                .i_inv        (w_info.inv),
                .i_invertible (w_info.invertible),
                .o_res        (w_res[r * 3 + c])
            );
        end
    end

    assign o_r00         = w_res[0];
    assign o_r01         = w_res[1];
    assign o_r02         = w_res[2];
    assign o_r10         = w_res[3];
    assign o_r11         = w_res[4];
    assign o_r12         = w_res[5];
    assign o_r20         = w_res[6];
    assign o_r21         = w_res[7];
    assign o_r22         = w_res[8];
    assign o_det_residue = r_info_d2.det;
    assign o_invertible  = r_info_d2.invertible;

endmodule

[design/mmi_checker.sv]
// ----------------------------------------------------------------------------
// mmi_checker: port-level checks for the modular 3x3 inverse
// Watches the top level's ports for latency, range and singular-key behaviour,
// and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module mmi_checker
    import mmi_pkg::*;
#(
    parameter int MODULUS = MODULUS_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [4:0] o_r00,
    input logic [4:0] o_r01,
    input logic [4:0] o_r02,
    input logic [4:0] o_r10,
    input logic [4:0] o_r11,
    input logic [4:0] o_r12,
    input logic [4:0] o_r20,
    input logic [4:0] o_r21,
    input logic [4:0] o_r22,
    input logic [4:0] o_det_residue,
    input logic       o_invertible
);

    localparam t_res M = mod_const(MODULUS);

    // Every accepted transaction is followed by a raised o_done.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##8 o_done)
        else $error("result missing eight cycles after an accepted transaction");

    // Every delivered entry is a reduced residue.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_det_residue < M) && (o_r00 < M) && (o_r01 < M) && (o_r02 < M)
                && (o_r10 < M) && (o_r11 < M) && (o_r12 < M) && (o_r20 < M)
                && (o_r21 < M) && (o_r22 < M))
        else $error("result entry outside the residue range");

    // A singular key gives an all-zero inverse.
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_invertible) |-> (o_r00 == '0) && (o_r01 == '0) && (o_r02 == '0)
                && (o_r10 == '0) && (o_r11 == '0) && (o_r12 == '0) && (o_r20 == '0)
                && (o_r21 == '0) && (o_r22 == '0))
        else $error("singular key gave a nonzero inverse entry");

    // A zero determinant never has an inverse, and a unit determinant always does.
    a_det_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_det_residue != '0) || !o_invertible)
                && ((o_det_residue != 5'd1) || o_invertible))
        else $error("invertible flag disagrees with the determinant");

endmodule

bind modular_matrix_inverse_3x3 mmi_checker #(
    .MODULUS (MODULUS)
) u_mmi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_r00         (o_r00),
    .o_r01         (o_r01),
    .o_r02         (o_r02),
    .o_r10         (o_r10),
    .o_r11         (o_r11),
    .o_r12         (o_r12),
    .o_r20         (o_r20),
    .o_r21         (o_r21),
    .o_r22         (o_r22),
    .o_det_residue (o_det_residue),
    .o_invertible  (o_invertible)
);
